// ===== rtl/core/tte_pkg.sv =====
`default_nettype none
package tte_pkg;

    localparam int SLOTS = 16;
    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [31:0] MAX_INTERVAL = 32'hFFFF_FFFF / 4;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_EXPIRE = 2'd2,
        CMD_QUERY  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        K_ADDED    = 3'd0,
        K_ADD_REJ  = 3'd1,
        K_DELETED  = 3'd2,
        K_DEL_IGN  = 3'd3,
        K_EXPIRED  = 3'd4,
        K_EXP_DONE = 3'd5,
        K_TIME     = 3'd6
    } kind_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] now_ms;
        logic [31:0] interval_ms;
        logic [3:0]  handle;
        logic [15:0] release_mask;
    } req_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  timer_id;
        logic        last;
        logic        no_wait;
        logic        no_timeout;
        logic [29:0] remaining_ms;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SCAN_RD,
        ST_SCAN_EV,
        ST_FINISH,
        ST_OUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic decide;
        logic scan_start;
        logic scan_rd;
        logic scan_ev;
        logic finish;
    } ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_need;
        logic scan_end;
        logic stop;
        logic emit;
        logic out_full;
    } sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/tte_ram.sv =====
`default_nettype none
module tte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/core/tte_ctrl.sv =====
`default_nettype none
module tte_ctrl
    import tte_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire sts_t sts,
    output ctl_t      ctl
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.load = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (sts.scan_need)
                begin
                    ctl.scan_start = 1'b1;
                    state_next = ST_SCAN_RD;
                end
                else if (!sts.out_full)
                begin
                    ctl.decide = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN_RD:
            begin
                if (sts.scan_end || sts.stop)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    ctl.scan_rd = 1'b1;
                    state_next = ST_SCAN_EV;
                end
            end
            ST_SCAN_EV:
            begin
                if (!(sts.emit && sts.out_full))
                begin
                    ctl.scan_ev = 1'b1;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_FINISH:
            begin
                if (!sts.out_full)
                begin
                    ctl.finish = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/core/tte_dp.sv =====
`default_nettype none
module tte_dp
    import tte_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire req_t in_data,
    input  wire ctl_t ctl,
    output sts_t      sts,
    output logic      out_valid,
    input  wire logic out_ready,
    output rsp_t      out_data
);

    req_t            req_reg;
    logic [SW-1:0]   order_reg [SLOTS];
    logic [SW-1:0]   freed_reg [SLOTS];
    logic [CW-1:0]   active_count_reg, freed_count_reg, fresh_next_reg;
    logic [CW-1:0]   rd_reg, wr_reg;
    logic [SW-1:0]   cur_reg;
    logic            ev_hold_reg;
    logic            any_reg, nowait_reg;
    logic [29:0]     best_reg;
    logic            ov_reg, ov_next;
    rsp_t            od_reg, od_next;

    logic [31:0]     start_rd;
    logic [29:0]     period_rd;
    logic            st_we;
    logic [SW-1:0]   st_waddr;
    logic [31:0]     st_wdata;
    logic            pd_we;
    logic [SW-1:0]   raddr;

    // add / delete decisions
    logic            full, too_big, can_add;
    logic [SW-1:0]   new_slot;
    logic [SLOTS-1:0] hit;
    logic            found;
    logic [SW-1:0]   hit_pos;

    assign too_big = req_reg.interval_ms > MAX_INTERVAL;
    assign full = active_count_reg >= CW'(SLOTS);
    assign can_add = !too_big && !full &&
                     (freed_count_reg != '0 || fresh_next_reg < CW'(SLOTS));
    assign new_slot = (freed_count_reg != '0) ?
                      freed_reg[SW'(freed_count_reg - 1'b1)] : SW'(fresh_next_reg);

    always_comb
    begin
        hit_pos = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            hit[i] = (CW'(i) < active_count_reg) && (order_reg[i] == req_reg.handle[SW-1:0]);
        end
        found = |hit;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (hit[i])
            begin
                hit_pos = SW'(i);
            end
        end
    end

    // scan evaluation
    logic [31:0] elapsed;
    logic        due, rel;
    logic [29:0] left;
    assign elapsed = req_reg.now_ms - start_rd;
    assign due = elapsed >= {2'b00, period_rd};
    assign left = period_rd - elapsed[29:0];
    assign rel = req_reg.release_mask[cur_reg];

    assign sts.scan_need = (req_reg.cmd == CMD_EXPIRE || req_reg.cmd == CMD_QUERY);
    assign sts.scan_end = rd_reg >= active_count_reg;
    assign sts.stop = nowait_reg;
    assign sts.emit = due && req_reg.cmd == CMD_EXPIRE;
    assign sts.out_full = ov_reg && !out_ready;

    // hold the read address on the current timer while its evaluation waits
    assign raddr = ev_hold_reg ? cur_reg : order_reg[SW'(rd_reg)];
    assign st_we = (ctl.decide && req_reg.cmd == CMD_ADD && can_add)
                   || (ctl.scan_ev && sts.emit && !rel);
    assign st_waddr = ctl.decide ? new_slot : cur_reg;
    assign st_wdata = req_reg.now_ms;
    assign pd_we = ctl.decide && req_reg.cmd == CMD_ADD && can_add;

    tte_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_start (
        .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
        .raddr(raddr), .rdata(start_rd)
    );

    tte_ram #(.WIDTH(30), .DEPTH(SLOTS)) u_period (
        .clk(clk), .we(pd_we), .waddr(new_slot), .wdata(req_reg.interval_ms[29:0]),
        .raddr(raddr), .rdata(period_rd)
    );

    always_comb
    begin
        ov_next = ov_reg && !out_ready;
        od_next = od_reg;
        if (ctl.decide)
        begin
            ov_next = 1'b1;
            od_next = '0;
            od_next.last = 1'b1;
            if (req_reg.cmd == CMD_ADD)
            begin
                if (can_add)
                begin
                    od_next.kind = K_ADDED;
                    od_next.timer_id = 4'(new_slot);
                end
                else
                begin
                    od_next.kind = K_ADD_REJ;
                end
            end
            else
            begin
                od_next.timer_id = req_reg.handle;
                od_next.kind = found ? K_DELETED : K_DEL_IGN;
            end
        end
        if (ctl.scan_ev && sts.emit)
        begin
            ov_next = 1'b1;
            od_next = '0;
            od_next.kind = K_EXPIRED;
            od_next.timer_id = 4'(cur_reg);
        end
        if (ctl.finish)
        begin
            ov_next = 1'b1;
            od_next = '0;
            od_next.last = 1'b1;
            if (req_reg.cmd == CMD_EXPIRE)
            begin
                od_next.kind = K_EXP_DONE;
            end
            else
            begin
                od_next.kind = K_TIME;
                od_next.no_wait = nowait_reg;
                od_next.no_timeout = !nowait_reg && !any_reg;
                od_next.remaining_ms = nowait_reg ? '0 : best_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            req_reg <= in_data;
        end
        if (ctl.scan_rd)
        begin
            cur_reg <= raddr;
        end
        if (ctl.decide && req_reg.cmd == CMD_ADD && can_add)
        begin
            order_reg[SW'(active_count_reg)] <= new_slot;
        end
        if (ctl.decide && req_reg.cmd == CMD_DELETE && found)
        begin
            for (int i = 0; i < SLOTS - 1; i++)
            begin
                if (SW'(i) >= hit_pos)
                begin
                    order_reg[i] <= order_reg[i+1];
                end
            end
            if (freed_count_reg < CW'(SLOTS))
            begin
                freed_reg[SW'(freed_count_reg)] <= req_reg.handle[SW-1:0];
            end
        end
        if (ctl.scan_ev && req_reg.cmd == CMD_EXPIRE)
        begin
            if (!(due && rel))
            begin
                order_reg[SW'(wr_reg)] <= cur_reg;
            end
            else if (freed_count_reg < CW'(SLOTS))
            begin
                freed_reg[SW'(freed_count_reg)] <= cur_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_count_reg <= '0;
            freed_count_reg <= '0;
            fresh_next_reg <= '0;
            rd_reg <= '0;
            wr_reg <= '0;
            ev_hold_reg <= 1'b0;
            any_reg <= 1'b0;
            nowait_reg <= 1'b0;
            best_reg <= '0;
            ov_reg <= 1'b0;
            od_reg <= '0;
        end
        else
        begin
            ov_reg <= ov_next;
            od_reg <= od_next;
            if (ctl.decide)
            begin
                if (req_reg.cmd == CMD_ADD)
                begin
                    if (can_add)
                    begin
                        active_count_reg <= active_count_reg + 1'b1;
                        if (freed_count_reg != '0)
                        begin
                            freed_count_reg <= freed_count_reg - 1'b1;
                        end
                        else
                        begin
                            fresh_next_reg <= fresh_next_reg + 1'b1;
                        end
                    end
                end
                else
                begin
                    if (found)
                    begin
                        active_count_reg <= active_count_reg - 1'b1;
                        if (freed_count_reg < CW'(SLOTS))
                        begin
                            freed_count_reg <= freed_count_reg + 1'b1;
                        end
                    end
                end
            end
            if (ctl.scan_start)
            begin
                rd_reg <= '0;
                wr_reg <= '0;
                any_reg <= 1'b0;
                nowait_reg <= 1'b0;
                best_reg <= '0;
            end
            if (ctl.scan_rd)
            begin
                rd_reg <= rd_reg + 1'b1;
                ev_hold_reg <= 1'b1;
            end
            if (ctl.scan_ev)
            begin
                ev_hold_reg <= 1'b0;
                if (req_reg.cmd == CMD_EXPIRE)
                begin
                    if (!(due && rel))
                    begin
                        wr_reg <= wr_reg + 1'b1;
                    end
                    else if (freed_count_reg < CW'(SLOTS))
                    begin
                        freed_count_reg <= freed_count_reg + 1'b1;
                    end
                end
                else
                begin
                    if (due)
                    begin
                        nowait_reg <= 1'b1;
                    end
                    else if (!any_reg || left < best_reg)
                    begin
                        best_reg <= left;
                    end
                    any_reg <= 1'b1;
                end
            end
            if (ctl.finish && req_reg.cmd == CMD_EXPIRE)
            begin
                active_count_reg <= wr_reg;
            end
        end
    end

    assign out_valid = ov_reg;
    assign out_data = od_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        active_count_reg <= CW'(SLOTS))
        else $error("active count overflow");
    a_freed_bound: assert property (@(posedge clk) disable iff (!rst_n)
        freed_count_reg <= CW'(SLOTS))
        else $error("freed count overflow");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.decide || ctl.finish) |-> !(ov_reg && !out_ready))
        else $error("result overwritten");
    a_wr_le_rd: assert property (@(posedge clk) disable iff (!rst_n)
        wr_reg <= rd_reg)
        else $error("compaction ahead of scan");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/timer_table_expiry_engine_core.sv =====
// Interval timer table with expiry engine.
// Request channel in_valid/in_ready carries req_t (add, delete, expire,
// query); response channel out_valid/out_ready carries rsp_t items, with
// last set on the final item of each request.
// Add and delete give their single result, registered in the decide state
// once the output register is free (table search is a parallel compare
// over the slot list).
// Expire and query walk the active list, a read step per active timer
// (registered RAM read of start/interval) and then an evaluate step,
// followed by finish and out states; the final result is registered in
// finish, and the next request is taken after the out state.
// A query stops at the first timer already due.
// One request is in progress at a time; in_ready is high only when idle.
// A single output register holds each result; while the receiver stalls,
// the walk waits on that register and no state is lost.
// Reset clears the list, free stack and fresh-slot counts; slot time
// stores are not cleared and are only read for active timers.
`default_nettype none
module timer_table_expiry_engine_core
    import tte_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire req_t in_data,
    output logic      out_valid,
    input  wire logic out_ready,
    output rsp_t      out_data
);

    ctl_t ctl;
    sts_t sts;

    tte_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .sts(sts), .ctl(ctl)
    );

    tte_dp u_dp (
        .clk(clk), .rst_n(rst_n), .in_data(in_data), .ctl(ctl), .sts(sts),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

endmodule
`default_nettype wire
